[rtl/skvt_pkg.sv]
// ---------------------------------------------------------------------------
// skvt_pkg: shared types and constants for the key/value table
// Table sizing, action and status codes, the stored record type and the
// name normalization used on insert and modify.
// ---------------------------------------------------------------------------
package skvt_pkg;

   localparam int CAPACITY      = 16;
   localparam int NAME_BYTES    = 8;

   localparam int KEY_W         = 32;
   localparam int NAME_W        = 8 * NAME_BYTES;
   localparam int NAME_PORT_W   = 64;
   localparam int ADDR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W       = $clog2(CAPACITY + 1);
   localparam int ENTRY_COUNT_W = 5;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_MODIFY = 2'd2;
   localparam logic [1:0] ACT_FIND   = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [NAME_W-1:0] name;
   } rec_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      rec_type           rec;
   } wr_req_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_req_type;

   // keep the low bytes up to the first zero byte, clear everything after it
   function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_PORT_W-1:0] raw);
      logic [NAME_W-1:0] res;
      logic              live;
      res  = '0;
      live = 1'b1;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (raw[8*i +: 8] == 8'h00) live = 1'b0;
         if (live) res[8*i +: 8] = raw[8*i +: 8];
      end
      return res;
   endfunction

endpackage

[rtl/skvt_ram.sv]
// ---------------------------------------------------------------------------
// skvt_ram: record store
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module skvt_ram (
   input  logic                 clock,
   input  skvt_pkg::wr_req_type wr_req,
   input  skvt_pkg::rd_req_type rd_req,
   output skvt_pkg::rec_type    rd_rec
);
   import skvt_pkg::*;

   rec_type mem [CAPACITY];
   rec_type rd_rec_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.rec;
      end
      if (rd_req.en) begin
         rd_rec_ff <= mem[rd_req.addr];
      end
   end

   assign rd_rec = rd_rec_ff;

endmodule

[rtl/skvt_ctrl.sv]
// ---------------------------------------------------------------------------
// skvt_ctrl: table sequencer
// Scans live slots through the store's read port, then inserts, deletes,
// renames or fetches, and registers the result.
// ---------------------------------------------------------------------------
module skvt_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_action,
   input  logic signed [skvt_pkg::KEY_W-1:0] req_key,
   input  logic [skvt_pkg::NAME_PORT_W-1:0] req_entry_name,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [skvt_pkg::NAME_PORT_W-1:0] rsp_found_name,
   output logic [skvt_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count,
   output skvt_pkg::wr_req_type             wr_req,
   output skvt_pkg::rd_req_type             rd_req,
   input  skvt_pkg::rec_type                rd_rec
);
   import skvt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_MOVE   = 3'd3;
   localparam logic [2:0] S_FETCH  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [1:0]               act_ff, act_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic [NAME_W-1:0]        name_ff, name_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic                     hit_ff, hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [NAME_PORT_W-1:0]   rsp_found_ff, rsp_found_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [COUNT_W-1:0]       count_dec;
   logic                     last_scanned;

   assign count_dec    = count_ff - COUNT_W'(1);
   assign last_scanned = (COUNT_W'(addr_ff) == count_dec);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      name_in       = name_ff;
      addr_in       = addr_ff;
      pos_in        = pos_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      wr_req        = '0;
      rd_req        = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in  = req_action;
               key_in  = req_key;
               name_in = normalize_name(req_entry_name);
               addr_in = '0;
               hit_in  = 1'b0;
               if (count_ff == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  rd_req.en   = 1'b1;
                  rd_req.addr = '0;
                  state_in    = S_SCAN;
               end
            end
         end

         // read data belongs to the slot at addr_ff
         S_SCAN: begin
            if (rd_rec.key == key_ff) begin
               hit_in   = 1'b1;
               pos_in   = addr_ff;
               state_in = S_DECIDE;
            end else if (last_scanned) begin
               state_in = S_DECIDE;
            end else begin
               addr_in     = addr_ff + ADDR_W'(1);
               rd_req.en   = 1'b1;
               rd_req.addr = addr_in;
            end
         end

         S_DECIDE: begin
            rsp_status_in = STATUS_MISS;
            rsp_found_in  = '0;
            state_in      = S_IDLE;
            case (act_ff)
               ACT_INSERT: begin
                  if (!key_ff[KEY_W-1] && !hit_ff) begin
                     if (count_ff == COUNT_W'(CAPACITY)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_req.en       = 1'b1;
                        wr_req.addr     = ADDR_W'(count_ff);
                        wr_req.rec.key  = key_ff;
                        wr_req.rec.name = name_ff;
                        count_in        = count_ff + COUNT_W'(1);
                        rsp_status_in   = STATUS_OK;
                     end
                  end
               end
               // hole is refilled from the last live slot
               ACT_DELETE: begin
                  if (hit_ff) begin
                     if (COUNT_W'(pos_ff) == count_dec) begin
                        count_in      = count_dec;
                        rsp_status_in = STATUS_OK;
                     end else begin
                        rd_req.en   = 1'b1;
                        rd_req.addr = ADDR_W'(count_dec);
                        state_in    = S_MOVE;
                     end
                  end
               end
               ACT_MODIFY: begin
                  if (hit_ff) begin
                     wr_req.en       = 1'b1;
                     wr_req.addr     = pos_ff;
                     wr_req.rec.key  = key_ff;
                     wr_req.rec.name = name_ff;
                     rsp_status_in   = STATUS_OK;
                  end
               end
               ACT_FIND: begin
                  if (hit_ff) begin
                     rd_req.en   = 1'b1;
                     rd_req.addr = pos_ff;
                     state_in    = S_FETCH;
                  end
               end
               default: begin
                  rsp_status_in = STATUS_MISS;
               end
            endcase
            rsp_valid_in = (state_in == S_IDLE);
         end

         S_MOVE: begin
            wr_req.en     = 1'b1;
            wr_req.addr   = pos_ff;
            wr_req.rec    = rd_rec;
            count_in      = count_dec;
            rsp_status_in = STATUS_OK;
            rsp_found_in  = '0;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end

         S_FETCH: begin
            rsp_status_in = STATUS_OK;
            rsp_found_in  = NAME_PORT_W'(rd_rec.name);
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_valid_in) rsp_count_in = ENTRY_COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_ff        <= key_in;
      name_ff       <= name_in;
      addr_ff       <= addr_in;
      pos_ff        <= pos_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_name  = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

[rtl/sorted_key_value_table_top.sv]
// result strobe registered from S_DECIDE, after the scan reads its slots in S_SCAN
// (up to the match, else every live slot; none when empty); busy drops with the strobe
// throughput: one item at a time, set by the linear scan over the store read port
// a find that hits or a delete that refills a hole also passes S_FETCH or S_MOVE
// reset empties the table at once; slot contents stay as they are
// the result strobe lasts one cycle and is never held off
// ---------------------------------------------------------------------------
// sorted_key_value_table_top: bounded key/name table
// Insert, delete, modify and find on signed keys (insert refuses negative keys), one result per item.
// ---------------------------------------------------------------------------
module sorted_key_value_table_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_action,
   input  logic signed [skvt_pkg::KEY_W-1:0]    req_key,
   input  logic [skvt_pkg::NAME_PORT_W-1:0]     req_entry_name,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [skvt_pkg::NAME_PORT_W-1:0]     rsp_found_name,
   output logic [skvt_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count
);
   import skvt_pkg::*;

   wr_req_type wr_req;
   rd_req_type rd_req;
   rec_type    rd_rec;

   skvt_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_entry_name  (req_entry_name),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found_name  (rsp_found_name),
      .rsp_entry_count (rsp_entry_count),
      .wr_req          (wr_req),
      .rd_req          (rd_req),
      .rd_rec          (rd_rec)
   );

   skvt_ram u_ram (
      .clock  (clock),
      .wr_req (wr_req),
      .rd_req (rd_req),
      .rd_rec (rd_rec)
   );

endmodule

[rtl/skvt_checker.sv]
// ---------------------------------------------------------------------------
// skvt_checker: port-level checks for the key/value table
// Watches the command and result ports of the top level.
// ---------------------------------------------------------------------------
module skvt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [1:0]                         rsp_status,
   input logic [skvt_pkg::NAME_PORT_W-1:0]   rsp_found_name,
   input logic [skvt_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);
   import skvt_pkg::*;

   // an accepted item keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // a result only follows a cycle of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without item in progress");

   a_miss_zero_name: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_found_name == '0))
      else $error("found name not zero on failed action");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_MISS ||
                     rsp_status == STATUS_FULL))
      else $error("undefined status code");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= ENTRY_COUNT_W'(CAPACITY)))
      else $error("entry count above capacity");

endmodule

bind sorted_key_value_table_top skvt_checker u_skvt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_found_name  (rsp_found_name),
   .rsp_entry_count (rsp_entry_count)
);
